FILE: rtl/slab_object_allocator_assert.svh
// Assertion macros for the slab object allocator.
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SOA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SOA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SOA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define SOA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/soa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab object allocator package
// Sizes, codes, payload types and the sequencer state type.
// ----------------------------------------------------------------------------
package soa_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int META_BYTES   = 64;
   localparam int HEADER_BYTES = 568;
   localparam int MAX_SLABS    = 16;
   localparam int PAGE_OBJ_CAP = 512;
   localparam int NSLOTS       = MAX_SLABS + 1;

   localparam int SLOT_W    = $clog2(NSLOTS);
   localparam int OBJ_W     = $clog2(PAGE_OBJ_CAP);
   localparam int LINK_W    = $clog2(PAGE_OBJ_CAP + 1);
   localparam int SIZE_W    = 12;
   localparam int OFF_W     = 12;
   localparam int MINP_W    = 5;
   localparam int DIV_W     = $clog2(PAGE_BYTES);
   localparam int PO_W      = $clog2(MAX_SLABS);
   localparam int ADDR_W    = SLOT_W + OBJ_W;
   localparam int MEM_DEPTH = NSLOTS * PAGE_OBJ_CAP;

   localparam logic [LINK_W-1:0] NIL        = LINK_W'(PAGE_OBJ_CAP);
   localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(8);
   localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(8);
   localparam logic [MINP_W-1:0] RESET_MINP = MINP_W'(1);

   localparam logic MODE_ALLOC  = 1'b0;
   localparam logic MODE_FREE   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   localparam logic CSR_OBJECT_SIZE = 1'b0;
   localparam logic CSR_MIN_PARTIAL = 1'b1;

   typedef enum logic [1:0] {
      SS_FREE    = 2'd0,
      SS_PARTIAL = 2'd1,
      SS_FULL    = 2'd2,
      SS_CACHE   = 2'd3
   } slot_state_type;

   typedef enum logic [3:0] {
      ST_DIV0_GO,
      ST_DIV0_WAIT,
      ST_DIV1_GO,
      ST_DIV1_WAIT,
      ST_CLEAR,
      ST_BUILD,
      ST_IDLE,
      ST_A_CHOOSE,
      ST_A_SCAN,
      ST_A_POP,
      ST_A_LINK,
      ST_F_CHECK,
      ST_F_SCAN_A,
      ST_F_SCAN_B,
      ST_SHIFT,
      ST_RESP
   } soa_state_type;

   typedef struct packed {
      logic              mode;
      logic [4:0]        slot;
      logic [8:0]        object_index;
   } soa_req_type;

   typedef struct packed {
      logic              status;
      logic [4:0]        object_slot;
      logic [8:0]        object_number;
      logic [11:0]       object_offset;
      logic              slab_created;
      logic              slab_released;
      logic [4:0]        released_slot;
   } soa_rsp_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } soa_div_status_type;

endpackage

FILE: rtl/slab_object_allocator.sv
`timescale 1ns / 1ps
// An allocation pops the head of the cache list, else of the first slab on the partial list; a
// slab that fills is shifted off the partial list. With neither, the pool slots are scanned for
// a free slab, whose object list is built before the pop. A free of a slot beyond the pool goes
// straight to the result; otherwise the object is linked back and a released slab shifted out.
// Throughput: one request at a time; busy stays high until the strobe and drops after it.
// Reset and object size writes run two divisions and a cache list rebuild.
// ----------------------------------------------------------------------------
// Slab object allocator
// Allocates and frees fixed-size objects over a cache page and a pool of slabs.
// ----------------------------------------------------------------------------
module slab_object_allocator
   import soa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  soa_req_type       req_data,
   output logic              rsp_strobe,
   output soa_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

`include "slab_object_allocator_assert.svh"

   soa_state_type      state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [MINP_W-1:0]  minp_ff;
   logic [LINK_W-1:0]  cnt0_ff, cnt1_ff;
   soa_req_type        req_ff;
   soa_rsp_type        res_ff;
   logic [SLOT_W-1:0]  cur_ff;
   logic [MINP_W-1:0]  po_idx_ff;
   logic [LINK_W-1:0]  bidx_ff;
   logic               build_alloc_ff;
   logic [OFF_W-1:0]   prod_ff;
   logic [MINP_W-1:0]  plen_ff;

   logic [LINK_W-1:0]  head_ff  [NSLOTS];
   logic [LINK_W-1:0]  used_ff  [NSLOTS];
   slot_state_type     sstat_ff [NSLOTS];
   logic [SLOT_W-1:0]  po_ff    [MAX_SLABS];

   logic [LINK_W-1:0]  link_mem [MEM_DEPTH];
   logic [LINK_W-1:0]  rd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [LINK_W-1:0]  mem_wdata;

   logic               div_go;
   logic [DIV_W-1:0]   div_dividend;
   soa_div_status_type div_stat;
   logic [LINK_W-1:0]  div_cnt;

   logic               csr_write, req_take;
   logic [LINK_W-1:0]  cur_head, cur_used, cur_cnt, used_inc, bidx_next;
   slot_state_type     cur_sstat;
   logic [SLOT_W-1:0]  po_rd;
   logic               build_done, pop_full, free_bad, free_full, free_scan;
   logic               scan_more, scan_hit;
   logic [MINP_W-1:0]  plen_free;
   logic [OFF_W-1:0]   start_off;

   soa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (size_ff),
      .stat     (div_stat)
   );

   assign div_dividend = (state_ff == ST_DIV0_GO) ? DIV_W'(PAGE_BYTES - HEADER_BYTES)
                                                  : DIV_W'(PAGE_BYTES - META_BYTES);
   assign div_cnt = (div_stat.quotient > DIV_W'(PAGE_OBJ_CAP)) ? NIL
                                                               : LINK_W'(div_stat.quotient);

   assign cur_head  = head_ff[cur_ff];
   assign cur_used  = used_ff[cur_ff];
   assign cur_sstat = sstat_ff[cur_ff];
   assign cur_cnt   = (cur_ff == '0) ? cnt0_ff : cnt1_ff;
   assign used_inc  = cur_used + LINK_W'(1);
   assign bidx_next = bidx_ff + LINK_W'(1);
   assign po_rd     = po_ff[po_idx_ff[PO_W-1:0]];
   assign start_off = (cur_ff == '0) ? OFF_W'(HEADER_BYTES) : OFF_W'(META_BYTES);

   assign csr_write  = csr_valid && csr_ready;
   assign req_take   = start && !busy;
   assign build_done = bidx_ff == cur_cnt;
   assign pop_full   = (cur_ff != '0) && (used_inc == cnt1_ff);
   assign free_bad   = (cur_sstat == SS_FREE) || ({1'b0, req_ff.object_index} >= cur_cnt);
   assign free_full  = cur_sstat == SS_FULL;
   assign plen_free  = plen_ff + MINP_W'(free_full);
   assign free_scan  = plen_free > minp_ff;
   assign scan_more  = (po_idx_ff < plen_ff) && (po_idx_ff < MINP_W'(MAX_SLABS));
   assign scan_hit   = (cur_ff < SLOT_W'(NSLOTS)) && (cur_used == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_DIV0_GO:   state_in = ST_DIV0_WAIT;
         ST_DIV0_WAIT: if (div_stat.done) state_in = ST_DIV1_GO;
         ST_DIV1_GO:   state_in = ST_DIV1_WAIT;
         ST_DIV1_WAIT: if (div_stat.done) state_in = ST_CLEAR;
         ST_CLEAR:     state_in = ST_BUILD;
         ST_BUILD: begin
            if (build_done) state_in = build_alloc_ff ? ST_A_POP : ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_write && csr_index == CSR_OBJECT_SIZE) begin
               state_in = ST_DIV0_GO;
            end else if (req_take) begin
               if (req_data.mode == MODE_ALLOC) state_in = ST_A_CHOOSE;
               else if (req_data.slot > SLOT_W'(MAX_SLABS)) state_in = ST_RESP;
               else state_in = ST_F_CHECK;
            end
         end
         ST_A_CHOOSE: begin
            if (head_ff[0] != NIL || plen_ff != '0) state_in = ST_A_POP;
            else if (cnt1_ff == '0) state_in = ST_RESP;
            else state_in = ST_A_SCAN;
         end
         ST_A_SCAN: begin
            if (cur_sstat == SS_FREE) state_in = ST_BUILD;
            else if (cur_ff == SLOT_W'(MAX_SLABS)) state_in = ST_RESP;
         end
         ST_A_POP:    state_in = (cur_head >= NIL) ? ST_RESP : ST_A_LINK;
         ST_A_LINK:   state_in = pop_full ? ST_SHIFT : ST_RESP;
         ST_F_CHECK:  state_in = (!free_bad && free_scan) ? ST_F_SCAN_A : ST_RESP;
         ST_F_SCAN_A: state_in = scan_more ? ST_F_SCAN_B : ST_RESP;
         ST_F_SCAN_B: state_in = scan_hit ? ST_SHIFT : ST_F_SCAN_A;
         ST_SHIFT:    if (po_idx_ff >= plen_ff) state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = state_ff != ST_IDLE;
      rsp_strobe = state_ff == ST_RESP;
      csr_ready  = (state_ff == ST_IDLE) && !start;
      div_go     = (state_ff == ST_DIV0_GO) || (state_ff == ST_DIV1_GO);
      mem_we     = 1'b0;
      mem_waddr  = {cur_ff, bidx_ff[OBJ_W-1:0]};
      mem_wdata  = (bidx_next < cur_cnt) ? bidx_next : NIL;
      mem_raddr  = {cur_ff, cur_head[OBJ_W-1:0]};
      case (state_ff)
         ST_BUILD: mem_we = !build_done;
         ST_F_CHECK: begin
            mem_we    = !free_bad;
            mem_waddr = {cur_ff, req_ff.object_index};
            mem_wdata = cur_head;
         end
         default: mem_we = 1'b0;
      endcase
   end

   assign rsp_data = res_ff;

   always_ff @(posedge clock) begin
      if (mem_we) link_mem[mem_waddr] <= mem_wdata;
      rd_ff <= link_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DIV0_GO;
         size_ff  <= RESET_SIZE;
         minp_ff  <= RESET_MINP;
         plen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_DIV0_WAIT: if (div_stat.done) cnt0_ff <= div_cnt;
            ST_DIV1_WAIT: if (div_stat.done) cnt1_ff <= div_cnt;
            ST_CLEAR: begin
               for (int s = 0; s < NSLOTS; s++) begin
                  head_ff[s]  <= NIL;
                  used_ff[s]  <= '0;
                  sstat_ff[s] <= (s == 0) ? SS_CACHE : SS_FREE;
               end
               plen_ff        <= '0;
               cur_ff         <= '0;
               bidx_ff        <= '0;
               build_alloc_ff <= 1'b0;
            end
            ST_BUILD: begin
               if (!build_done) begin
                  bidx_ff <= bidx_next;
               end else begin
                  head_ff[cur_ff] <= (cur_cnt != '0) ? '0 : NIL;
                  used_ff[cur_ff] <= '0;
                  if (build_alloc_ff) begin
                     sstat_ff[cur_ff]         <= SS_PARTIAL;
                     po_ff[plen_ff[PO_W-1:0]] <= cur_ff;
                     plen_ff                  <= plen_ff + MINP_W'(1);
                     res_ff.slab_created      <= 1'b1;
                  end
               end
            end
            ST_IDLE: begin
               if (csr_write) begin
                  if (csr_index == CSR_OBJECT_SIZE) begin
                     size_ff <= (csr_wdata < MIN_SIZE) ? MIN_SIZE : csr_wdata;
                  end else begin
                     minp_ff <= csr_wdata[MINP_W-1:0];
                  end
               end else if (req_take) begin
                  req_ff    <= req_data;
                  res_ff    <= '0;
                  po_idx_ff <= '0;
                  cur_ff    <= (req_data.mode == MODE_FREE) ? req_data.slot : '0;
               end
            end
            ST_A_CHOOSE: begin
               if (head_ff[0] != NIL) begin
                  cur_ff <= '0;
               end else if (plen_ff != '0) begin
                  cur_ff <= po_rd;
               end else if (cnt1_ff == '0) begin
                  res_ff.status <= STATUS_FAIL;
               end else begin
                  cur_ff <= SLOT_W'(1);
               end
            end
            ST_A_SCAN: begin
               if (cur_sstat == SS_FREE) begin
                  bidx_ff        <= '0;
                  build_alloc_ff <= 1'b1;
               end else if (cur_ff == SLOT_W'(MAX_SLABS)) begin
                  res_ff.status <= STATUS_FAIL;
               end else begin
                  cur_ff <= cur_ff + SLOT_W'(1);
               end
            end
            ST_A_POP: begin
               if (cur_head >= NIL) begin
                  res_ff.status       <= STATUS_FAIL;
                  res_ff.slab_created <= 1'b0;
               end else begin
                  prod_ff              <= OFF_W'(cur_head[OBJ_W-1:0] * size_ff);
                  res_ff.object_slot   <= cur_ff;
                  res_ff.object_number <= cur_head[OBJ_W-1:0];
               end
            end
            ST_A_LINK: begin
               head_ff[cur_ff]      <= rd_ff;
               used_ff[cur_ff]      <= used_inc;
               res_ff.object_offset <= start_off + prod_ff;
               if (pop_full) begin
                  sstat_ff[cur_ff] <= SS_FULL;
                  po_idx_ff        <= MINP_W'(1);
               end
            end
            ST_F_CHECK: begin
               if (!free_bad) begin
                  if (free_full) begin
                     sstat_ff[cur_ff]         <= SS_PARTIAL;
                     po_ff[plen_ff[PO_W-1:0]] <= cur_ff;
                     plen_ff                  <= plen_free;
                  end
                  used_ff[cur_ff] <= cur_used - LINK_W'(1);
                  head_ff[cur_ff] <= {1'b0, req_ff.object_index};
                  po_idx_ff       <= '0;
               end
            end
            ST_F_SCAN_A: if (scan_more) cur_ff <= po_rd;
            ST_F_SCAN_B: begin
               po_idx_ff <= po_idx_ff + MINP_W'(1);
               if (scan_hit) begin
                  sstat_ff[cur_ff]     <= SS_FREE;
                  head_ff[cur_ff]      <= NIL;
                  res_ff.slab_released <= 1'b1;
                  res_ff.released_slot <= cur_ff;
               end
            end
            ST_SHIFT: begin
               if (po_idx_ff < plen_ff) begin
                  po_ff[PO_W'(po_idx_ff - MINP_W'(1))] <= po_rd;
                  po_idx_ff <= po_idx_ff + MINP_W'(1);
               end else if (plen_ff != '0) begin
                  plen_ff <= plen_ff - MINP_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   `SOA_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy, "result strobe while idle")
   `SOA_ASSERT_NEXT(a_take_busy, clock, reset, req_take, busy, "request accepted but not busy")
   `SOA_ASSERT_SAME(a_plen_range, clock, reset, 1'b1, plen_ff <= MINP_W'(MAX_SLABS),
                    "partial list longer than the pool")
   `SOA_ASSERT_SAME(a_fail_clean, clock, reset, rsp_strobe && rsp_data.status == STATUS_FAIL,
                    rsp_data.object_slot == '0 && !rsp_data.slab_created,
                    "failed allocation carries an object")

endmodule

FILE: rtl/soa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab object allocator divider
// Restoring divider, one quotient bit per cycle, for objects per page.
// ----------------------------------------------------------------------------
module soa_div
   import soa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [SIZE_W-1:0]  divisor,
   output soa_div_status_type stat
);

   localparam int CNT_W = $clog2(DIV_W);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [SIZE_W:0]    trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (go) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(DIV_W - 1);
         rem_in    = '0;
         quo_in    = dividend;
      end else if (active_ff) begin
         rem_in = fits ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule
